// File: hw/rtl/bdeq_pkg.sv
// bdeq_pkg: shared types and constants of the bounded double-ended queue
// used by the top level and by its port checker

package bdeq_pkg;

    localparam int DATA_W = 32;
    localparam int OP_W   = 3;
    localparam int CAP_W  = 7;
    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 72;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_REAR  = 3'd1,
        OP_DEL_FRONT = 3'd2,
        OP_DEL_REAR  = 3'd3,
        OP_QUERY     = 3'd4
    } op_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_READ = 2'b10
    } state_t;

    // first member lands in the highest bits
    typedef struct packed {
        logic              is_full;
        logic              is_empty;
        logic [DATA_W-1:0] rear_value;
        logic [DATA_W-1:0] front_value;
        logic              success;
    } result_t;

    localparam int RESULT_W = $bits(result_t);

endpackage

// File: hw/rtl/bounded_double_ended_queue.sv
// bounded_double_ended_queue: top level, ring control, cached end entries, output register
// depends on bdeq_pkg and bdeq_ram

// A deque of signed 32-bit values kept as a ring in one ram, with a head pointer
// and an entry count. Each input transaction carries an operation (insert front,
// insert rear, delete front, delete rear, query) and returns exactly one result
// transaction: success, front and rear entries after the operation (all ones when
// empty), and the empty and full flags. Full means count >= min(capacity, DEPTH).
// The front and rear entries are cached in registers, so inserts and queries need no
// ram read. A delete that leaves the queue non-empty needs the new end entry from
// the ram's registered read data, which it takes in ST_READ. One transaction is in
// work at a time; a finished result waits in the output register and the next
// transaction is taken as soon as that register is free or drained.
// No clearing pass after reset: ram entries are only read after they are written.
// capacity may be written only while idle.

module bounded_double_ended_queue #(
    parameter int DEPTH = 64
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [bdeq_pkg::CAP_W-1:0]    cfg_wdata,   // capacity
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [bdeq_pkg::S_TDATA_W-1:0] s_tdata,    // operation[2:0], value[34:3]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [bdeq_pkg::M_TDATA_W-1:0] m_tdata     // success[0], front_value[32:1],
                                                       // rear_value[64:33], is_empty[65],
                                                       // is_full[66]
);

    import bdeq_pkg::*;

    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;
    localparam logic [CMPW-1:0] DEPTH_C   = CMPW'(DEPTH);
    localparam logic [AW:0]     DEPTH_P   = (AW + 1)'(DEPTH);
    localparam logic [AW-1:0]   LAST_IDX  = AW'(DEPTH - 1);
    localparam logic [CAP_W-1:0] CAP_RST  = 7'd64;

    function automatic logic [AW-1:0] ring_add(input logic [AW-1:0] b, input logic [AW-1:0] o);
        logic [AW:0] s;
        s = {1'b0, b} + {1'b0, o};
        if (s >= DEPTH_P)
        begin
            s = s - DEPTH_P;
        end
        return s[AW-1:0];
    endfunction

    state_t            state_reg, state_next;
    logic [AW-1:0]     head_reg, head_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CAP_W-1:0]  cap_reg, cap_next;
    logic [DATA_W-1:0] front_reg, front_next;
    logic [DATA_W-1:0] rear_reg, rear_next;
    logic              out_valid_reg, out_valid_next;
    result_t           out_reg, out_next;
    logic              pend_front_reg, pend_front_next;
    logic              pend_full_reg, pend_full_next;

    op_t               op;
    logic [DATA_W-1:0] val;
    logic              accept;
    logic [CMPW-1:0]   cap_eff;
    logic              full, empty;
    logic [AW-1:0]     head_dec, head_inc;
    logic [CW-1:0]     count_m2;
    logic              ok, rd_need, pend_front;
    logic              wr_en;
    logic [AW-1:0]     wr_addr, rd_addr;
    logic [DATA_W-1:0] rd_data;
    logic [CW-1:0]     cnt_upd;
    logic [AW-1:0]     head_upd;
    logic [DATA_W-1:0] front_upd, rear_upd;
    logic              empty_upd, full_upd;

    assign op       = op_t'(s_tdata[OP_W-1:0]);
    assign val      = s_tdata[OP_W +: DATA_W];
    assign s_tready = (state_reg == ST_IDLE) && (!out_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;

    assign cap_eff  = (CMPW'(cap_reg) > DEPTH_C) ? DEPTH_C : CMPW'(cap_reg);
    assign full     = CMPW'(count_reg) >= cap_eff;
    assign empty    = (count_reg == '0);
    assign head_dec = (head_reg == '0) ? LAST_IDX : head_reg - AW'(1);
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + AW'(1);
    assign count_m2 = count_reg - CW'(2);

    // operation decode, ring pointer update
    always_comb
    begin
        head_upd   = head_reg;
        cnt_upd    = count_reg;
        front_upd  = front_reg;
        rear_upd   = rear_reg;
        ok         = 1'b0;
        wr_en      = 1'b0;
        wr_addr    = head_dec;
        rd_need    = 1'b0;
        rd_addr    = head_inc;
        pend_front = 1'b0;
        unique case (op)
            OP_INS_FRONT:
            begin
                if (!full)
                begin
                    head_upd  = head_dec;
                    wr_en     = 1'b1;
                    wr_addr   = head_dec;
                    cnt_upd   = count_reg + CW'(1);
                    front_upd = val;
                    if (empty)
                    begin
                        rear_upd = val;
                    end
                    ok = 1'b1;
                end
            end
            OP_INS_REAR:
            begin
                if (!full)
                begin
                    wr_en    = 1'b1;
                    wr_addr  = ring_add(head_reg, count_reg[AW-1:0]);
                    cnt_upd  = count_reg + CW'(1);
                    rear_upd = val;
                    if (empty)
                    begin
                        front_upd = val;
                    end
                    ok = 1'b1;
                end
            end
            OP_DEL_FRONT:
            begin
                if (!empty)
                begin
                    head_upd = head_inc;
                    cnt_upd  = count_reg - CW'(1);
                    ok       = 1'b1;
                    if (count_reg > CW'(1))
                    begin
                        rd_need    = 1'b1;
                        rd_addr    = head_inc;
                        pend_front = 1'b1;
                    end
                end
            end
            OP_DEL_REAR:
            begin
                if (!empty)
                begin
                    cnt_upd = count_reg - CW'(1);
                    ok      = 1'b1;
                    if (count_reg > CW'(1))
                    begin
                        rd_need = 1'b1;
                        rd_addr = ring_add(head_reg, count_m2[AW-1:0]);
                    end
                end
            end
            OP_QUERY:
            begin
                ok = 1'b1;
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    assign empty_upd = (cnt_upd == '0);
    assign full_upd  = CMPW'(cnt_upd) >= cap_eff;

    // register next values
    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        cap_next        = cfg_we ? cfg_wdata : cap_reg;
        front_next      = front_reg;
        rear_next       = rear_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_next        = out_reg;
        pend_front_next = pend_front_reg;
        pend_full_next  = pend_full_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    head_next  = head_upd;
                    count_next = cnt_upd;
                    front_next = front_upd;
                    rear_next  = rear_upd;
                    if (rd_need)
                    begin
                        state_next      = ST_READ;
                        pend_front_next = pend_front;
                        pend_full_next  = full_upd;
                    end
                    else
                    begin
                        out_valid_next       = 1'b1;
                        out_next.success     = ok;
                        out_next.front_value = empty_upd ? '1 : front_upd;
                        out_next.rear_value  = empty_upd ? '1 : rear_upd;
                        out_next.is_empty    = empty_upd;
                        out_next.is_full     = full_upd;
                    end
                end
            end
            ST_READ:
            begin
                // ram data holds the new end entry; output register is free here
                state_next           = ST_IDLE;
                out_valid_next       = 1'b1;
                out_next.success     = 1'b1;
                out_next.is_empty    = 1'b0;
                out_next.is_full     = pend_full_reg;
                if (pend_front_reg)
                begin
                    front_next           = rd_data;
                    out_next.front_value = rd_data;
                    out_next.rear_value  = rear_reg;
                end
                else
                begin
                    rear_next            = rd_data;
                    out_next.front_value = front_reg;
                    out_next.rear_value  = rd_data;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            head_reg      <= '0;
            count_reg     <= '0;
            cap_reg       <= CAP_RST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            count_reg     <= count_next;
            cap_reg       <= cap_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        front_reg      <= front_next;
        rear_reg       <= rear_next;
        out_reg        <= out_next;
        pend_front_reg <= pend_front_next;
        pend_full_reg  <= pend_full_next;
    end

    // inserts write only, deletes read only: no same-cycle overlap on an entry
    bdeq_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (accept && wr_en),
        .wr_addr (wr_addr),
        .wr_data (val),
        .rd_en   (accept && rd_need),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {(M_TDATA_W - RESULT_W)'(0), out_reg};

endmodule

// File: hw/rtl/bdeq_ram.sv
// bdeq_ram: generic single-write, single-read ram with registered read data
// no dependencies

module bdeq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                   clk,
    input  logic                                   wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                       wr_data,
    input  logic                                   rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                       rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hw/rtl/bdeq_checker.sv
// bdeq_checker: port-level assertions for the bounded double-ended queue
// depends on bdeq_pkg; bound to bounded_double_ended_queue at the end of this file

module bdeq_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [bdeq_pkg::M_TDATA_W-1:0] m_tdata
);

    import bdeq_pkg::*;

    logic s_acc;
    assign s_acc = s_tvalid && s_tready;

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // an unclaimed result blocks new transactions
    a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |-> !s_tready)
        else $error("input taken while result waits");

    // every accepted transaction is followed by a valid result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_acc |-> ##2 ($past(m_tvalid) || m_tvalid))
        else $error("result missing after transaction");

    // empty queue reports all ones at both ends
    a_empty_ones: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[65] |-> (m_tdata[64:1] == {(2 * DATA_W){1'b1}}))
        else $error("empty result with end values");

endmodule

bind bounded_double_ended_queue bdeq_checker u_bdeq_checker (.*);

// File: verif/tb_bounded_double_ended_queue.sv
// tb_bounded_double_ended_queue: self-checking testbench for the bounded double-ended queue
// drives random and directed deque operations with random stalls on both streams
// depends on bdeq_pkg and bounded_double_ended_queue
`timescale 1ns / 100ps

module tb_bounded_double_ended_queue;

    import bdeq_pkg::*;

    localparam int RING_DEPTH = 64;
    localparam int IDX_W      = $clog2(RING_DEPTH);
    localparam int PHASE_OPS  = 80;
    localparam int MAX_PRINTS = 100;

    localparam logic [OP_W-1:0] OP_RESERVED_FIRST = 3'd5;
    localparam logic [OP_W-1:0] OP_RESERVED_LAST  = 3'd7;

    typedef struct {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] value;
    } deq_req_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 cfg_we = 1'b0;
    logic [CAP_W-1:0]     cfg_wdata = '0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    deq_req_t    op_queue[$];
    result_t     outcome_queue[$];
    deq_req_t    cur_req;
    logic        req_taken = 1'b0;
    int unsigned queued_count = 0;
    int unsigned accepted_count = 0;
    int unsigned result_count = 0;
    int unsigned error_count = 0;
    int unsigned tx_gap = 0;
    int unsigned tx_burst = 0;
    int unsigned rx_stall = 0;
    int unsigned rx_burst = 0;
    result_t     got_result;
    result_t     want_result;

    logic [DATA_W-1:0] shadow_ring [RING_DEPTH];
    logic [IDX_W-1:0]  shadow_head = '0;
    int unsigned       shadow_count = 0;
    logic [CAP_W-1:0]  shadow_cap = CAP_W'(64);

    bounded_double_ended_queue #(
        .DEPTH(RING_DEPTH)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_error(input string msg);
        error_count++;
        if (error_count <= MAX_PRINTS)
            $display("ERROR at %0t: %s", $time, msg);
    endtask

    // one deque operation on the shadow state, returns the result it owes
    function automatic result_t apply_deque_op(input deq_req_t req);
        result_t          res;
        int unsigned      cap;
        logic             full;
        logic             empty;
        logic [IDX_W-1:0] idx;
        cap   = (shadow_cap > RING_DEPTH) ? RING_DEPTH : shadow_cap;
        full  = shadow_count >= cap;
        empty = shadow_count == 0;
        res.success = 1'b0;
        case (req.op)
            OP_INS_FRONT:
                if (!full)
                begin
                    shadow_head = shadow_head - 1'b1;
                    shadow_ring[shadow_head] = req.value;
                    shadow_count++;
                    res.success = 1'b1;
                end
            OP_INS_REAR:
                if (!full)
                begin
                    idx = shadow_head + IDX_W'(shadow_count);
                    shadow_ring[idx] = req.value;
                    shadow_count++;
                    res.success = 1'b1;
                end
            OP_DEL_FRONT:
                if (!empty)
                begin
                    shadow_head = shadow_head + 1'b1;
                    shadow_count--;
                    res.success = 1'b1;
                end
            OP_DEL_REAR:
                if (!empty)
                begin
                    shadow_count--;
                    res.success = 1'b1;
                end
            OP_QUERY:
                res.success = 1'b1;
            default:
                res.success = 1'b0;
        endcase
        if (shadow_count == 0)
        begin
            res.front_value = '1;
            res.rear_value  = '1;
            res.is_empty    = 1'b1;
        end
        else
        begin
            idx = shadow_head + IDX_W'(shadow_count - 1);
            res.front_value = shadow_ring[shadow_head];
            res.rear_value  = shadow_ring[idx];
            res.is_empty    = 1'b0;
        end
        res.is_full = shadow_count >= cap;
        return res;
    endfunction

    // mostly short gaps, a few long ones, and now and then a run with none
    function automatic int unsigned pick_gap(inout int unsigned burst);
        int unsigned r;
        if (burst > 0)
        begin
            burst--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3)
        begin
            burst = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic logic [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h7fff_ffff;
            1:       return 32'h8000_0000;
            2:       return 32'hffff_ffff;
            3:       return '0;
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_op(input logic [OP_W-1:0] op, input logic [DATA_W-1:0] value);
        deq_req_t req;
        req.op    = op;
        req.value = value;
        op_queue = {op_queue, req};
        queued_count++;
    endtask

    // each segment picks a new insert share, from mostly filling to mostly draining, so both full and empty are reached
    task automatic queue_random_phase(input int unsigned n_ops);
        int unsigned done;
        int unsigned seg_len;
        int unsigned ins_pct;
        int unsigned r;
        logic [OP_W-1:0] op;
        done = 0;
        ins_pct = 90;
        while (done < n_ops)
        begin
            seg_len = $urandom_range(15, 45);
            for (int i = 0; i < seg_len && done < n_ops; i++)
            begin
                r = $urandom_range(0, 99);
                if (r < 4)
                    op = OP_W'($urandom_range(OP_RESERVED_FIRST, OP_RESERVED_LAST));
                else if (r < 10)
                    op = OP_QUERY;
                else if ($urandom_range(0, 99) < ins_pct)
                    op = $urandom_range(0, 1) ? OP_INS_REAR : OP_INS_FRONT;
                else
                    op = $urandom_range(0, 1) ? OP_DEL_REAR : OP_DEL_FRONT;
                queue_op(op, pick_value());
                done++;
            end
            case ($urandom_range(0, 3))
                0:       ins_pct = 85;
                1:       ins_pct = 15;
                2:       ins_pct = 50;
                default: ins_pct = 30;
            endcase
        end
    endtask

    task automatic wait_drained();
        while (!(accepted_count == queued_count && outcome_queue.size() == 0))
            @(negedge clk);
    endtask

    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        wait_drained();
        repeat (4) @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= cap;
        @(negedge clk);
        cfg_we    <= 1'b0;
        shadow_cap = cap;
    endtask

    // input side: a transaction accepted here owes exactly one result
    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            outcome_queue = {outcome_queue, apply_deque_op(cur_req)};
            accepted_count++;
            req_taken = 1'b1;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || req_taken))
        begin
            req_taken = 1'b0;
            if (tx_gap > 0)
            begin
                tx_gap--;
                s_tvalid <= 1'b0;
            end
            else if (op_queue.size() > 0)
            begin
                cur_req = op_queue[0];
                op_queue.delete(0);
                s_tdata  <= S_TDATA_W'({cur_req.value, cur_req.op});
                s_tvalid <= 1'b1;
                tx_gap = pick_gap(tx_burst);
            end
            else
                s_tvalid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (rx_stall > 0)
            begin
                rx_stall--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                rx_stall = pick_gap(rx_burst);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got_result = result_t'(m_tdata[RESULT_W-1:0]);
            if (outcome_queue.size() == 0)
                flag_error($sformatf("result %0d arrived with nothing outstanding",
                                     result_count));
            else
            begin
                want_result = outcome_queue[0];
                outcome_queue.delete(0);
                if (got_result.success !== want_result.success)
                    flag_error($sformatf("result %0d success got %0b want %0b", result_count,
                                         got_result.success, want_result.success));
                if (got_result.front_value !== want_result.front_value)
                    flag_error($sformatf("result %0d front_value got %h want %h", result_count,
                                         got_result.front_value, want_result.front_value));
                if (got_result.rear_value !== want_result.rear_value)
                    flag_error($sformatf("result %0d rear_value got %h want %h", result_count,
                                         got_result.rear_value, want_result.rear_value));
                if (got_result.is_empty !== want_result.is_empty)
                    flag_error($sformatf("result %0d is_empty got %0b want %0b", result_count,
                                         got_result.is_empty, want_result.is_empty));
                if (got_result.is_full !== want_result.is_full)
                    flag_error($sformatf("result %0d is_full got %0b want %0b", result_count,
                                         got_result.is_full, want_result.is_full));
            end
            result_count++;
        end
    end

    initial
    begin
        #5_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        logic [CAP_W-1:0] cap_plan [14];
        cap_plan = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd2, 7'd65, 7'd7,
                     7'd40, 7'd96, 7'd3, 7'd16, 7'd64, 7'd0, 7'd50};
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty queue, reserved codes, extreme values, drain past empty
        queue_op(OP_QUERY, '0);
        queue_op(OP_DEL_FRONT, '0);
        queue_op(OP_DEL_REAR, '1);
        for (int c = OP_RESERVED_FIRST; c <= OP_RESERVED_LAST; c++)
            queue_op(OP_W'(c), $urandom());
        queue_op(OP_INS_FRONT, 32'h7fff_ffff);
        queue_op(OP_INS_REAR, 32'h8000_0000);
        queue_op(OP_INS_FRONT, '0);
        queue_op(OP_INS_REAR, 32'hffff_ffff);
        queue_op(OP_QUERY, '1);
        queue_op(OP_RESERVED_FIRST, 32'h5555_aaaa);
        queue_op(OP_DEL_FRONT, '0);
        queue_op(OP_DEL_REAR, '0);
        queue_op(OP_DEL_REAR, '0);
        queue_op(OP_DEL_FRONT, '0);
        queue_op(OP_DEL_REAR, '0);
        queue_op(OP_INS_REAR, 32'h1234_5678);

        // queue contents carry over so a lower capacity can land below the count
        foreach (cap_plan[p])
        begin
            write_capacity(cap_plan[p]);
            queue_random_phase(PHASE_OPS);
        end

        wait_drained();
        repeat (10) @(negedge clk);
        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
